[src/mi3_pkg.sv]
package mi3_pkg;

    localparam int ENTRY_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    localparam int W     = ENTRY_WIDTH;
    localparam int PW    = 2 * W;          // product of two entries
    localparam int AW    = 2 * W + 1;      // signed adjugate entry
    localparam int AMW   = 2 * W;          // adjugate magnitude
    localparam int DW    = 3 * W + 2;      // signed determinant
    localparam int QB    = W + 1;          // quotient bits kept by a lane
    localparam int XTW   = QB + DW;        // dividend width inside a lane
    localparam int SH    = 2 * FRACTION_BITS + 1;
    localparam int NLANE = 9;

    localparam int FRONT_LAT = 6;
    localparam int LANE_LAT  = QB + 2;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT;

    typedef logic signed [W-1:0] t_entry;

    typedef struct packed {
        t_entry m00; t_entry m01; t_entry m02;
        t_entry m10; t_entry m11; t_entry m12;
        t_entry m20; t_entry m21; t_entry m22;
    } t_in_beat;

    typedef struct packed {
        t_entry r00; t_entry r01; t_entry r02;
        t_entry r10; t_entry r11; t_entry r12;
        t_entry r20; t_entry r21; t_entry r22;
        logic   singular;
    } t_out_beat;

    typedef struct packed {
        logic [AMW-1:0] mag;
        logic           neg;
    } t_lane_in;

    typedef struct packed {
        logic [DW-1:0]              d;
        logic                       zero;
        t_lane_in [NLANE-1:0]       lane;
    } t_front;

endpackage

[src/mi3_ifs.sv]
interface mi3_in_if;
    logic              valid;
    logic              ready;
    mi3_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mi3_out_if;
    logic               valid;
    logic               ready;
    mi3_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/mi3_front.sv]
module mi3_front (
    input  logic              i_clk,
    input  logic              i_en,
    input  mi3_pkg::t_in_beat i_beat,
    output mi3_pkg::t_front   o_front
);
    import mi3_pkg::*;

    t_entry                mm     [3][3];
    logic signed [PW-1:0]  n_pt   [3][3];
    logic signed [PW-1:0]  n_pu   [3][3];
    logic signed [PW-1:0]  r_pt   [3][3];
    logic signed [PW-1:0]  r_pu   [3][3];
    t_entry                r_c2a  [3];
    t_entry                r_c2b  [3];
    logic signed [AW-1:0]  r_adj  [3][3];
    logic signed [AW-1:0]  r_adj3 [3][3];
    logic signed [AW-1:0]  r_adj4 [3][3];
    logic signed [AW-1:0]  r_adj5 [3][3];
    logic signed [AW:0]    r_pl   [3];
    logic signed [AW:0]    r_ph   [3];
    logic signed [DW-1:0]  r_p    [3];
    logic signed [DW-1:0]  r_det;
    t_front                n_front;
    t_front                r_front;

    always_comb begin
        int i1, i2, j1, j2;
        mm[0][0] = i_beat.m00; mm[0][1] = i_beat.m01; mm[0][2] = i_beat.m02;
        mm[1][0] = i_beat.m10; mm[1][1] = i_beat.m11; mm[1][2] = i_beat.m12;
        mm[2][0] = i_beat.m20; mm[2][1] = i_beat.m21; mm[2][2] = i_beat.m22;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                i1 = (i == 2) ? 0 : i + 1;
                i2 = (i == 0) ? 2 : i - 1;
                j1 = (j == 2) ? 0 : j + 1;
                j2 = (j == 0) ? 2 : j - 1;
                n_pt[i][j] = mm[j1][i1] * mm[j2][i2];
                n_pu[i][j] = mm[j1][i2] * mm[j2][i1];
            end
        end
    end

    // magnitudes and signs for the division lanes
    always_comb begin
        logic                 det_neg;
        logic signed [DW-1:0] det_abs;
        logic signed [AW-1:0] a_abs;
        det_neg = r_det[DW-1];
        det_abs = det_neg ? -r_det : r_det;
        n_front.d    = det_abs;
        n_front.zero = (r_det == '0);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a_abs = r_adj5[i][j][AW-1] ? -r_adj5[i][j] : r_adj5[i][j];
                n_front.lane[i*3+j].mag = a_abs[AMW-1:0];
                n_front.lane[i*3+j].neg = r_adj5[i][j][AW-1] ^ det_neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt     <= n_pt;
            r_pu     <= n_pu;
            r_c2a[0] <= mm[0][2];
            r_c2a[1] <= mm[1][2];
            r_c2a[2] <= mm[2][2];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_adj[i][j] <= AW'(r_pt[i][j]) - AW'(r_pu[i][j]);
                end
            end
            r_c2b  <= r_c2a;
            r_adj3 <= r_adj;
            // adjugate row two split into unsigned low and signed high halves
            for (int k = 0; k < 3; k++) begin
                r_pl[k] <= $signed({1'b0, r_adj[2][k][W-1:0]}) * r_c2b[k];
                r_ph[k] <= $signed(r_adj[2][k][AW-1:W]) * r_c2b[k];
            end
            r_adj4 <= r_adj3;
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= (DW'(r_ph[k]) <<< W) + DW'(r_pl[k]);
            end
            r_adj5  <= r_adj4;
            r_det   <= r_p[0] + r_p[1] + r_p[2];
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

[src/mi3_div_lane.sv]
module mi3_div_lane (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  mi3_pkg::t_lane_in     i_lane,
    input  logic [mi3_pkg::DW-1:0] i_d,
    output mi3_pkg::t_entry       o_res
);
    import mi3_pkg::*;

    localparam logic [QB-1:0] SBIT = QB'(1) << (W - 1);

    logic [DW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DW-1:0] r_d   [QB+1];
    logic          r_big [QB+1];
    logic          r_neg [QB+1];
    logic [DW-1:0] n_rem [QB+1];
    logic [QB-1:0] n_low [QB+1];
    logic [QB-1:0] n_q   [QB+1];
    logic          n_big [QB+1];
    logic [DW:0]   w_t   [QB];
    logic [DW:0]   w_df  [QB];
    logic          w_ge  [QB];
    logic [XTW-1:0] n_x;
    t_entry        n_res;
    t_entry        r_res;

    always_comb begin
        n_x      = XTW'(i_lane.mag) << SH;
        n_rem[0] = n_x[XTW-1:QB];
        n_low[0] = n_x[QB-1:0];
        n_q[0]   = '0;
        // high part already at or above the divisor: quotient overflows
        n_big[0] = (n_x[XTW-1:QB] >= i_d);
        for (int s = 1; s <= QB; s++) begin
            w_t[s-1]  = {r_rem[s-1], r_low[s-1][QB-1]};
            w_df[s-1] = w_t[s-1] - {1'b0, r_d[s-1]};
            w_ge[s-1] = (w_t[s-1] >= {1'b0, r_d[s-1]});
            n_rem[s]  = w_ge[s-1] ? w_df[s-1][DW-1:0] : w_t[s-1][DW-1:0];
            n_low[s]  = r_low[s-1] << 1;
            n_q[s]    = {r_q[s-1][QB-2:0], w_ge[s-1]};
            n_big[s]  = r_big[s-1];
        end
    end

    // round half away from zero, sign and saturate
    always_comb begin
        logic [QB:0]   q1;
        logic [QB-1:0] q;
        logic [QB-1:0] lim;
        logic [QB-1:0] mag;
        logic          neg;
        q1    = ({1'b0, r_q[QB]} + (QB+1)'(1)) >> 1;
        q     = q1[QB-1:0];
        neg   = r_neg[QB] && (q != '0);
        lim   = neg ? SBIT : SBIT - QB'(1);
        mag   = (r_big[QB] || (q > lim)) ? lim : q;
        n_res = neg ? -mag[W-1:0] : mag[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_low[0] <= n_low[0];
            r_q[0]   <= n_q[0];
            r_big[0] <= n_big[0];
            r_d[0]   <= i_d;
            r_neg[0] <= i_lane.neg;
            for (int s = 1; s <= QB; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
                r_big[s] <= n_big[s];
                r_d[s]   <= r_d[s-1];
                r_neg[s] <= r_neg[s-1];
            end
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[src/matrix3x3_inverse.sv]
// channel  dir  payload                         handshake
// i_in     in   m00..m22, signed Q16.16         valid/ready
// o_out    out  r00..r22 Q16.16, singular       valid/ready
//
// one matrix accepted per cycle while ready is high; a matrix passes through the adjugate and
// determinant front stages, the nine restoring divider lanes (one quotient bit per stage)
// and one output register.
// synchronous active-low reset clears the valid pipeline and the output stage.
// a stalled output beat waits in the output register while one more result
// lands in a skid register; only then does ready drop and the pipeline freeze.
module matrix3x3_inverse (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mi3_in_if.sink      i_in,
    mi3_out_if.source   o_out
);
    import mi3_pkg::*;

    logic            en;
    t_front          front;
    t_entry          res    [NLANE];
    logic            r_vld  [TOTAL_LAT];
    logic            r_zd   [LANE_LAT];
    t_out_beat       p_beat;
    logic            p_v;
    logic            r_ov;
    t_out_beat       r_out;
    logic            r_sv;
    t_out_beat       r_skid;

    assign en         = !r_sv;
    assign i_in.ready = en;

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_beat  (i_in.data),
        .o_front (front)
    );

    for (genvar k = 0; k < NLANE; k++) begin : g_lane
        mi3_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (front.lane[k]),
            .i_d    (front.d),
            .o_res  (res[k])
        );
    end

    // merge lanes; a zero determinant forces the entries to zero
    always_comb begin
        logic z;
        z = r_zd[LANE_LAT-1];
        p_beat.r00 = z ? '0 : res[0];
        p_beat.r01 = z ? '0 : res[1];
        p_beat.r02 = z ? '0 : res[2];
        p_beat.r10 = z ? '0 : res[3];
        p_beat.r11 = z ? '0 : res[4];
        p_beat.r12 = z ? '0 : res[5];
        p_beat.r20 = z ? '0 : res[6];
        p_beat.r21 = z ? '0 : res[7];
        p_beat.r22 = z ? '0 : res[8];
        p_beat.singular = z;
        p_v = r_vld[TOTAL_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zd[0] <= front.zero;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_zd[s] <= r_zd[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TOTAL_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int s = 1; s < TOTAL_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || o_out.ready) begin
            if (r_sv) begin
                r_ov  <= 1'b1;
                r_out <= r_skid;
                r_sv  <= 1'b0;
            end else begin
                r_ov  <= en && p_v;
                r_out <= p_beat;
            end
        end else if (en && p_v) begin
            r_skid <= p_beat;
            r_sv   <= 1'b1;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

endmodule
